FILE: hw/rtl/sobel_pkg.sv
package sobel_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] edge_red;
        logic [7:0] edge_green;
        logic [7:0] edge_blue;
        logic       row_end;
        logic       frame_end;
    } out_item_t;

    localparam logic [0:0] ADDR_LINE_WIDTH   = 1'b0;
    localparam logic [0:0] ADDR_FRAME_HEIGHT = 1'b1;
    localparam int unsigned ROOT_STEPS = 8;
    localparam logic [16:0] CLAMP_LIMIT = 17'd65280;
    localparam logic [12:0] HEIGHT_CAP = 13'd4096;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // accept the input transaction and do the line/window update
        logic root_step; // one bit of the rounded square roots
        logic restart;   // clear window and counters
    } sobel_cmd_t;

    typedef struct packed {
        logic have;      // the accepted transaction produced a result
        logic last;      // the result ends the frame
        logic idle;      // no frame is in progress
    } sobel_sts_t;

endpackage

FILE: hw/rtl/sobel_edge_magnitude_rgb.sv
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order, with zero
// padding at the image border and a rounded, 255-clamped magnitude per channel.
// A transaction that gives no result is accepted, then the registered
// line-store read is done before the next one; one that gives a result is
// accepted, runs the bit-serial square-root steps for the three channels in
// parallel, presents the result until it is taken, then does the store read.
// A flush with no frame in progress is accepted and dropped without effect.
// After a frame send exactly line_width+1 flush transactions to drain it.
// A configuration write abandons the frame in progress.
module sobel_edge_magnitude_rgb #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sobel_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sobel_pkg::out_item_t out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import sobel_pkg::*;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        cfg_write;
    sobel_cmd_t  cmd;
    sobel_sts_t  sts;
    logic        frame_idle;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && paddr[1:0] == 2'b00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd640;
            height_reg <= 13'd480;
        end
        else if (cfg_write && paddr[2] == ADDR_LINE_WIDTH)
            width_reg <= pwdata[10:0];
        else if (cfg_write && paddr[2] == ADDR_FRAME_HEIGHT)
            height_reg <= pwdata[12:0];
    end

    always_comb
    begin
        unique case (paddr[2])
            ADDR_LINE_WIDTH:   prdata = {21'd0, width_reg};
            ADDR_FRAME_HEIGHT: prdata = {19'd0, height_reg};
            default:           prdata = '0;
        endcase
    end

    sobel_datapath #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (in_data),
        .cmd          (cmd),
        .line_width   (width_reg),
        .frame_height (height_reg),
        .sts          (sts),
        .result       (out_data)
    );

    assign frame_idle = sts.idle;

    sobel_control u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .frame_idle (frame_idle),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cfg_write  (cfg_write),
        .sts        (sts),
        .cmd        (cmd)
    );

endmodule

FILE: hw/rtl/sobel_datapath.sv
module sobel_datapath #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sobel_pkg::in_item_t  item,
    input  sobel_pkg::sobel_cmd_t cmd,
    input  logic [10:0]          line_width,
    input  logic [12:0]          frame_height,
    output sobel_pkg::sobel_sts_t sts,
    output sobel_pkg::out_item_t result
);
    import sobel_pkg::*;

    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int WW = $clog2(MAX_LINE_WIDTH + 1);

    logic [23:0] upper_mem [MAX_LINE_WIDTH];
    logic [23:0] middle_mem [MAX_LINE_WIDTH];

    logic [23:0] win_reg [6];
    logic [23:0] win_next [6];
    logic [WW-1:0] col_reg, col_next;
    logic [12:0] row_reg, row_next;
    logic [WW-1:0] w_sat;
    logic [12:0] h_sat;

    // Read data of the two line stores for the current column.
    logic [23:0] up_rd_reg, mid_rd_reg;
    logic [CW-1:0] addr;

    // Square-root stage registers.
    logic [16:0] sum_reg [3];
    logic [16:0] sum_next [3];
    logic [7:0]  root_reg [3];
    logic [7:0]  bit_reg, bit_next;
    logic        row_end_reg, frame_end_reg, last_next, rowend_next, have_next;

    logic [23:0] pix;
    logic [23:0] g [3][3];
    logic [12:0] orow;
    logic [WW-1:0] ocol;
    logic        use_right;

    always_comb
    begin
        if (line_width < 11'd2)
            w_sat = WW'(2);
        else if (32'(line_width) > MAX_LINE_WIDTH)
            w_sat = WW'(MAX_LINE_WIDTH);
        else
            w_sat = WW'(line_width);
        if (frame_height < 13'd2)
            h_sat = 13'd2;
        else if (frame_height > HEIGHT_CAP)
            h_sat = HEIGHT_CAP;
        else
            h_sat = frame_height;
    end

    assign addr = col_reg[CW-1:0];

    // The store read is registered; the controller passes through S_READ between
    // a column change and the next take command, so the data is current.
    always_ff @(posedge clk)
    begin
        up_rd_reg  <= upper_mem[addr];
        mid_rd_reg <= middle_mem[addr];
        if (cmd.take)
        begin
            upper_mem[addr]  <= mid_rd_reg;
            middle_mem[addr] <= pix;
        end
    end

    always_comb
    begin
        logic signed [11:0] v [3][3];
        logic signed [11:0] gx, gy;
        logic [21:0] sq;
        pix = {item.pixel_blue, item.pixel_green, item.pixel_red};
        if (item.command || row_reg >= h_sat)
            pix = '0;
        have_next = 1'b0;
        orow = '0;
        ocol = '0;
        use_right = col_reg != '0;
        if (col_reg != '0)
        begin
            have_next = row_reg >= 13'd1;
            orow = row_reg - 13'd1;
            ocol = col_reg - WW'(1);
        end
        else
        begin
            have_next = row_reg >= 13'd2;
            orow = row_reg - 13'd2;
            ocol = w_sat - WW'(1);
        end
        if (orow >= h_sat)
            have_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            g[r][0] = win_reg[r];
            g[r][1] = win_reg[3+r];
        end
        g[0][2] = use_right ? up_rd_reg : '0;
        g[1][2] = use_right ? mid_rd_reg : '0;
        g[2][2] = use_right ? pix : '0;
        if (orow == 13'd0)
            for (int c = 0; c < 3; c++) g[0][c] = '0;
        if (orow == h_sat - 13'd1)
            for (int c = 0; c < 3; c++) g[2][c] = '0;
        if (ocol == '0)
            for (int r = 0; r < 3; r++) g[r][0] = '0;
        if (ocol == w_sat - WW'(1))
            for (int r = 0; r < 3; r++) g[r][2] = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    v[r][c] = 12'($unsigned(g[r][c][8*k +: 8]));
            gx = (v[0][2] + (v[1][2] <<< 1) + v[2][2]) - (v[0][0] + (v[1][0] <<< 1) + v[2][0]);
            gy = (v[2][0] + (v[2][1] <<< 1) + v[2][2]) - (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
            sq = 22'($unsigned(22'(gx) * 22'(gx) + 22'(gy) * 22'(gy)));
            sum_next[k] = (sq > 22'(CLAMP_LIMIT)) ? 17'h1FFFF : sq[16:0];
        end
        rowend_next = ocol == w_sat - WW'(1);
        last_next = rowend_next && orow == h_sat - 13'd1;
        win_next[0] = win_reg[3];
        win_next[1] = win_reg[4];
        win_next[2] = win_reg[5];
        win_next[3] = up_rd_reg;
        win_next[4] = mid_rd_reg;
        win_next[5] = pix;
        col_next = col_reg + WW'(1);
        row_next = row_reg;
        if (col_next >= w_sat)
        begin
            col_next = '0;
            row_next = row_reg + 13'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end
        else if (cmd.restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end
        else if (cmd.take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            for (int i = 0; i < 6; i++) win_reg[i] <= win_next[i];
        end
    end

    assign sts.have = have_next;
    assign sts.last = last_next;
    assign sts.idle = col_reg == '0 && row_reg == '0;

    // Bit-serial rounded root: largest n with n*(n-1) < s, one bit per step.
    always_comb
    begin
        bit_next = {1'b0, bit_reg[7:1]};
    end

    always_ff @(posedge clk)
    begin
        logic [7:0]  t;
        logic [16:0] p;
        if (cmd.take)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]  <= sum_next[k];
                root_reg[k] <= '0;
            end
            bit_reg       <= 8'h80;
            row_end_reg   <= rowend_next;
            frame_end_reg <= last_next;
        end
        else if (cmd.root_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                t = root_reg[k] | bit_reg;
                p = 17'(16'(t) * 16'(t - 8'd1));
                if (sum_reg[k] == 17'h1FFFF)
                    root_reg[k] <= 8'hFF;
                else if (p < sum_reg[k])
                    root_reg[k] <= t;
            end
            bit_reg <= bit_next;
        end
    end

    assign result.edge_red   = root_reg[0];
    assign result.edge_green = root_reg[1];
    assign result.edge_blue  = root_reg[2];
    assign result.row_end    = row_end_reg;
    assign result.frame_end  = frame_end_reg;

endmodule

FILE: hw/rtl/sobel_control.sv
module sobel_control (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_command,
    input  logic                  frame_idle,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  cfg_write,
    input  sobel_pkg::sobel_sts_t sts,
    output sobel_pkg::sobel_cmd_t cmd
);
    import sobel_pkg::*;

    typedef enum logic [3:0] {
        S_READ = 4'b0001,
        S_IDLE = 4'b0010,
        S_ROOT = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic last_reg, last_next;
    logic drop;

    // A flush while no frame is in progress is swallowed without effect.
    assign drop = in_command && frame_idle;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        last_next = last_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !drop)
                begin
                    cmd.take = 1'b1;
                    last_next = sts.last;
                    step_next = '0;
                    state_next = sts.have ? S_ROOT : S_READ;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(ROOT_STEPS - 1))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.restart = last_reg;
                    state_next = S_READ;
                end
            end
            default:
                state_next = S_READ;
        endcase
        if (cfg_write)
        begin
            cmd.restart = 1'b1;
            state_next = S_READ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_READ;
            step_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            last_reg <= last_next;
        end
    end

endmodule
